### hw/rtl/pvd_pkg.sv
// ----------------------------------------------------------------------------
// pvd_pkg: shared types and constants for the prefix varint byte decoder
// Field-length table, status codes, decoder state and result word layout.
// ----------------------------------------------------------------------------
`default_nettype none

package pvd_pkg;

  // Widths of the decoded fields
  localparam int unsigned ValueW   = 96;
  localparam int unsigned BitsW    = 7;
  localparam int unsigned BytesW   = 4;
  localparam int unsigned MaxBitsW = 7;
  localparam logic [MaxBitsW-1:0] MaxBitsReset = 7'd64;

  // Field length in bytes, indexed by (shift - 1), shift = 8 - marker position
  localparam logic [BytesW-1:0] LEN_TABLE [0:7] = '{
    4'd1, 4'd2, 4'd3, 4'd4, 4'd6, 4'd8, 4'd10, 4'd13
  };

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_ZERO_LEAD = 2'd1,
    ST_TRUNCATED = 2'd2,
    ST_TOO_WIDE  = 2'd3
  } status_e;

  // Field in progress
  typedef struct packed {
    logic [BytesW-1:0] bytes_left;   // 0: waiting for a lead byte
    logic [BytesW-1:0] field_len;
    logic [ValueW-1:0] accum;
    logic [BitsW-1:0]  value_bits;   // bit length of accum so far
  } dec_state_t;

  // One decoded field
  typedef struct packed {
    logic [ValueW-1:0] value;
    logic [BitsW-1:0]  value_bits;
    logic [BytesW-1:0] byte_count;
    status_e           status;
  } result_t;

  // Index of the highest set bit plus one, 0 for a zero byte
  function automatic logic [3:0] bit_len8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) begin
        n = 4'(i + 1);
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/pvd_step.sv
// ----------------------------------------------------------------------------
// pvd_step: one-byte decode step
// Given the field in progress and one byte, computes the next field state and
// whether a finished field (or an error) is reported, with its result word.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_step
  import pvd_pkg::*;
(
  input  dec_state_t          state_i,
  input  logic [7:0]          byte_i,
  input  logic                last_i,
  input  logic [MaxBitsW-1:0] max_bits_i,
  output dec_state_t          state_o,
  output logic                emit_o,
  output result_t             result_o
);

  // Lead byte decode: marker position, length, payload bits
  logic [3:0]        lead_len8;
  logic [2:0]        pos;
  logic [BytesW-1:0] lead_len;
  logic [7:0]        lead_bits;
  logic [3:0]        lead_nbits;

  assign lead_len8  = bit_len8(byte_i);
  assign pos        = 3'(lead_len8 - 4'd1);
  assign lead_len   = LEN_TABLE[3'd7 - pos];
  assign lead_bits  = byte_i & ~(8'hFF << pos);
  assign lead_nbits = bit_len8(lead_bits);

  // Continuation byte: shift in below, grow bit length by 8 once nonzero
  logic [ValueW-1:0] cont_accum;
  logic [BitsW-1:0]  cont_bits;
  logic [BytesW-1:0] cont_left;

  assign cont_accum = {state_i.accum[ValueW-9:0], byte_i};
  assign cont_bits  = (state_i.value_bits != '0) ? BitsW'(state_i.value_bits + BitsW'(8))
                                                  : BitsW'(bit_len8(byte_i));
  assign cont_left  = BytesW'(state_i.bytes_left - BytesW'(1));

  dec_state_t idle_state;
  assign idle_state = '{bytes_left: '0, field_len: '0, accum: '0, value_bits: '0};

  always_comb begin
    state_o  = state_i;
    emit_o   = 1'b0;
    result_o = '{value: '0, value_bits: '0, byte_count: BytesW'(1), status: ST_OK};

    if (state_i.bytes_left == '0) begin
      // lead byte
      if (byte_i == 8'h00) begin
        emit_o          = 1'b1;
        result_o.status = ST_ZERO_LEAD;
        state_o         = idle_state;
      end else if (lead_len == BytesW'(1)) begin
        emit_o              = 1'b1;
        result_o.value      = ValueW'(lead_bits);
        result_o.value_bits = BitsW'(lead_nbits);
        result_o.status     = (BitsW'(lead_nbits) > max_bits_i) ? ST_TOO_WIDE : ST_OK;
        state_o             = idle_state;
      end else if (last_i) begin
        emit_o          = 1'b1;
        result_o.status = ST_TRUNCATED;
        state_o         = idle_state;
      end else begin
        state_o.bytes_left = BytesW'(lead_len - BytesW'(1));
        state_o.field_len  = lead_len;
        state_o.accum      = ValueW'(lead_bits);
        state_o.value_bits = BitsW'(lead_nbits);
      end
    end else begin
      // continuation byte
      if (cont_left == '0) begin
        emit_o              = 1'b1;
        result_o.value      = cont_accum;
        result_o.value_bits = cont_bits;
        result_o.byte_count = state_i.field_len;
        result_o.status     = (cont_bits > max_bits_i) ? ST_TOO_WIDE : ST_OK;
        state_o             = idle_state;
      end else if (last_i) begin
        emit_o              = 1'b1;
        result_o.byte_count = BytesW'(state_i.field_len - cont_left);
        result_o.status     = ST_TRUNCATED;
        state_o             = idle_state;
      end else begin
        state_o.bytes_left = cont_left;
        state_o.accum      = cont_accum;
        state_o.value_bits = cont_bits;
      end
    end
  end

endmodule

`default_nettype wire

### hw/rtl/pvd_out_buf.sv
// ----------------------------------------------------------------------------
// pvd_out_buf: result output register with skid stage
// Holds the presented result word and one more, so the input side can still
// hand over a word while the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pvd_out_buf
  import pvd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    wr_valid_i,
  input  result_t wr_data_i,
  output logic    wr_ready_o,
  output logic    out_valid_o,
  output result_t out_data_o,
  input  logic    out_ready_i
);

  logic    out_valid_q, skid_valid_q;
  result_t out_data_q, skid_data_q;
  logic    out_free;

  // output slot can load when empty or being taken this cycle
  assign out_free   = !out_valid_q || out_ready_i;
  assign wr_ready_o = !skid_valid_q;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q || wr_valid_i;
      skid_valid_q <= 1'b0;
    end else if (wr_valid_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      out_data_q <= skid_valid_q ? skid_data_q : wr_data_i;
    end else if (wr_valid_i) begin
      skid_data_q <= wr_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

`default_nettype wire

### hw/rtl/prefix_varint_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// prefix_varint_byte_decoder_top: prefix-length varint byte stream decoder
// Decodes big-endian variable-length integers whose length is coded by the
// marker bit of the lead byte, one byte per cycle while s_axis_tready is high.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word
//  s_axis    in   tdata: data_byte[7:0]; tlast: buffer_end
//  m_axis    out  tdata: value_low, value_high, value_bits, byte_count; tuser: status
//  cfg       in   cfg_we_i / cfg_wdata_i: max_value_bits
//
//  One byte is taken per cycle while s_axis_tready is high; a field's result is
//  registered in the output or skid register when its completing (or failing)
//  byte is accepted. Throughput is set by the single decode register stage.
//  Reset clears the field in progress and sets max_value_bits to 64. A stall
//  on m_axis is absorbed by a skid stage for one word; then s_axis_tready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module prefix_varint_byte_decoder_top
  import pvd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // config
  input  logic                cfg_we_i,
  input  logic [MaxBitsW-1:0] cfg_wdata_i,
  // input byte stream
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // buffer_end
  // result stream
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [63:0] value_low, [95:64] value_high, [102:96] value_bits,
  // [106:103] byte_count, [111:107] zero
  output logic [111:0]        m_axis_tdata,
  output logic [1:0]          m_axis_tuser    // [1:0] status
);

  // configuration register
  logic [MaxBitsW-1:0] max_bits_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bits_q <= MaxBitsReset;
    end else if (cfg_we_i) begin
      max_bits_q <= cfg_wdata_i;
    end
  end

  // decode step
  dec_state_t state_q, state_d;
  logic       emit;
  result_t    result;
  logic       accept;

  assign accept = s_axis_tvalid && s_axis_tready;

  pvd_step u_step (
    .state_i    (state_q),
    .byte_i     (s_axis_tdata),
    .last_i     (s_axis_tlast),
    .max_bits_i (max_bits_q),
    .state_o    (state_d),
    .emit_o     (emit),
    .result_o   (result)
  );

  // field state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (accept) begin
      state_q <= state_d;
    end
  end

  // result register and skid
  result_t out_data;

  pvd_out_buf u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .wr_valid_i  (accept && emit),
    .wr_data_i   (result),
    .wr_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_data),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = {5'd0, out_data.byte_count, out_data.value_bits, out_data.value};
  assign m_axis_tuser = out_data.status;

endmodule

`default_nettype wire

### dv/prefix_varint_byte_decoder_checker.sv
// ----------------------------------------------------------------------------
// prefix_varint_byte_decoder_checker: field predictor and result scoreboard
// Watches every byte word taken on s_axis and decodes it with a private copy
// of the field state and the max_value_bits limit. Each word leaving m_axis
// is compared field by field with the oldest predicted field.
// ----------------------------------------------------------------------------
module prefix_varint_byte_decoder_checker
  import pvd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [MaxBitsW-1:0] cfg_wdata_i,
  input  logic                s_axis_tvalid,
  input  logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // [7:0] data_byte
  input  logic                s_axis_tlast,   // buffer_end
  input  logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [63:0] value_low, [95:64] value_high, [102:96] value_bits,
  // [106:103] byte_count, [111:107] zero
  input  logic [111:0]        m_axis_tdata,
  input  logic [1:0]          m_axis_tuser,   // [1:0] status
  output int                  pending_o,      // fields predicted, not yet seen
  output int                  checked_o,
  output int                  errors_o
);

  // Private decoder state
  logic [MaxBitsW-1:0] width_limit;
  logic [BytesW-1:0]   bytes_to_go;
  logic [BytesW-1:0]   field_total;
  logic [ValueW-1:0]   accum;
  result_t             predicted_fields[$];

  // Field length for a marker shift of 1..8
  function automatic logic [BytesW-1:0] len_for_shift(input int shift);
    case (shift)
      1:       return 4'd1;
      2:       return 4'd2;
      3:       return 4'd3;
      4:       return 4'd4;
      5:       return 4'd6;
      6:       return 4'd8;
      7:       return 4'd10;
      default: return 4'd13;
    endcase
  endfunction

  function automatic logic [BitsW-1:0] bit_length(input logic [ValueW-1:0] v);
    logic [BitsW-1:0] n;
    n = '0;
    for (int i = 0; i < ValueW; i++) begin
      if (v[i]) begin
        n = BitsW'(i + 1);
      end
    end
    return n;
  endfunction

  // Completed field: full value, width checked against the limit
  function automatic result_t finished_field(input logic [BytesW-1:0] nbytes);
    result_t r;
    r.value      = accum;
    r.value_bits = bit_length(accum);
    r.byte_count = nbytes;
    r.status     = (r.value_bits > width_limit) ? ST_TOO_WIDE : ST_OK;
    return r;
  endfunction

  function automatic result_t failed_field(input logic [BytesW-1:0] nbytes,
                                           input status_e st);
    result_t r;
    r            = '0;
    r.byte_count = nbytes;
    r.status     = st;
    return r;
  endfunction

  task automatic clear_field();
    bytes_to_go = '0;
    field_total = '0;
    accum       = '0;
  endtask

  // Advance the field state by one byte; queue a result if one is due
  task automatic decode_byte(input logic [7:0] b, input logic last);
    int               marker;
    int               shift;
    logic [BytesW-1:0] len;
    marker = 0;
    if (bytes_to_go == 0) begin
      if (b == 8'h00) begin
        predicted_fields.push_back(failed_field(4'd1, ST_ZERO_LEAD));
        clear_field();
      end else begin
        for (int i = 0; i < 8; i++) begin
          if (b[i]) begin
            marker = i;
          end
        end
        shift = 8 - marker;
        len   = len_for_shift(shift);
        accum = ValueW'(b & (8'hFF >> shift));
        if (len == 4'd1) begin
          predicted_fields.push_back(finished_field(4'd1));
          clear_field();
        end else if (last) begin
          predicted_fields.push_back(failed_field(4'd1, ST_TRUNCATED));
          clear_field();
        end else begin
          field_total = len;
          bytes_to_go = len - 4'd1;
        end
      end
    end else begin
      accum       = {accum[ValueW-9:0], b};
      bytes_to_go = bytes_to_go - 4'd1;
      if (bytes_to_go == 0) begin
        predicted_fields.push_back(finished_field(field_total));
        clear_field();
      end else if (last) begin
        predicted_fields.push_back(failed_field(field_total - bytes_to_go, ST_TRUNCATED));
        clear_field();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [95:0] want,
                             input logic [95:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
      errors_o++;
    end
  endtask

  // Compare outgoing words first, then predict from the incoming byte
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    result_t want;
    int      pushed;
    int      popped;
    if (!rst_ni) begin
      width_limit = MaxBitsReset;
      clear_field();
      predicted_fields.delete();
      checked_o = 0;
      errors_o  = 0;
      pending_o <= 0;
    end else begin
      pushed = 0;
      popped = 0;
      if (cfg_we_i) begin
        width_limit = cfg_wdata_i;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (predicted_fields.size() == 0) begin
          $display("%0t: result word with none expected, got data 0x%0h status %0d",
                   $time, m_axis_tdata, m_axis_tuser);
          errors_o++;
        end else begin
          want   = predicted_fields.pop_front();
          popped = 1;
          check_field("value_low", want.value[63:0], m_axis_tdata[63:0]);
          check_field("value_high", want.value[95:64], m_axis_tdata[95:64]);
          check_field("value_bits", want.value_bits, m_axis_tdata[102:96]);
          check_field("byte_count", want.byte_count, m_axis_tdata[106:103]);
          check_field("padding", '0, m_axis_tdata[111:107]);
          check_field("status", want.status, m_axis_tuser);
          checked_o++;
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pushed = predicted_fields.size();
        decode_byte(s_axis_tdata, s_axis_tlast);
        pushed = predicted_fields.size() - pushed;
      end
      pending_o <= pending_o + pushed - popped;
    end
  end

endmodule

### dv/tb_prefix_varint_byte_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_prefix_varint_byte_decoder_top: testbench for the varint byte decoder
// Feeds directed fields (zero lead byte, widest and narrowest fields, cut
// buffers) and then random buffers of mostly well-formed fields across a
// series of max_value_bits limits, with random gaps on both streams. The
// checker instance predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_prefix_varint_byte_decoder_top;
  import pvd_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int PhaseBytes   = 170;
  localparam int NumPhases    = 8;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                cfg_we_i      = 1'b0;
  logic [MaxBitsW-1:0] cfg_wdata_i   = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = '0;
  logic                s_axis_tlast  = 1'b0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [111:0]        m_axis_tdata;
  logic [1:0]          m_axis_tuser;

  int pending;
  int checked;
  int errors;
  int cycles       = 0;
  int bytes_sent   = 0;
  int limit_writes = 0;
  int sink_wait    = 0;
  bit src_pace     = 1'b1;
  bit snk_pace     = 1'b1;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  prefix_varint_byte_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  prefix_varint_byte_decoder_checker result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .pending_o     (pending),
    .checked_o     (checked),
    .errors_o      (errors)
  );

  // Result side: random stall after each word taken
  always @(posedge clk_i) begin : sink_ready
    int stall;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      sink_wait     <= 0;
    end else if (m_axis_tvalid && m_axis_tready) begin
      stall = snk_pace ? $urandom_range(0, 11) : 0;
      sink_wait     <= stall;
      m_axis_tready <= (stall == 0);
    end else if (sink_wait > 0) begin
      sink_wait     <= sink_wait - 1;
      m_axis_tready <= (sink_wait == 1);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("%0t: run stopped after %0d cycles, %0d results outstanding",
               $time, cycles, pending);
      $display("TEST FAILED");
      $finish;
    end
  end

  // Content byte with a bias toward all-zero and all-one
  function automatic logic [7:0] content_byte();
    case ($urandom_range(0, 3))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // One byte word; valid is held high across back-to-back words
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = src_pace ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  // Well-formed field for a marker shift; cut > 0 ends the buffer after that
  // many bytes, otherwise end_buf marks the completing byte as buffer end
  task automatic send_field(input int shift, input int cut, input logic end_buf);
    int         len;
    int         zeros;
    logic [7:0] marker;
    logic [7:0] b;
    logic       last;
    len    = LEN_TABLE[shift-1];
    zeros  = $urandom_range(0, len);
    marker = 8'h80 >> (shift - 1);
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        b = (zeros > 0) ? marker : (marker | (content_byte() & (marker - 8'd1)));
      end else begin
        b = (i < zeros) ? 8'h00 : content_byte();
      end
      last = (cut > 0) ? (i == cut - 1) : (end_buf && i == len - 1);
      send_byte(b, last);
      if (cut > 0 && i == cut - 1) begin
        break;
      end
    end
  endtask

  // Stop driving and wait until every predicted result has come out
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [MaxBitsW-1:0] v);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    limit_writes++;
  endtask

  initial begin : stimulus
    int                  target;
    int                  kind;
    int                  shift;
    logic [MaxBitsW-1:0] limit;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: zero lead, one-byte extremes, widest field, cut buffers
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'h01, 1'b0);
    repeat (12) send_byte(8'hFF, 1'b0);
    send_byte(8'h40, 1'b1);
    send_byte(8'h20, 1'b0);
    send_byte(8'hAB, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h40, 1'b0);
    send_byte(8'h00, 1'b1);

    // Random buffers, one limit setting per phase
    for (int phase = 0; phase < NumPhases; phase++) begin
      case (phase)
        0:       limit = MaxBitsReset;
        1:       limit = 7'd96;
        2:       limit = 7'd1;
        3:       limit = 7'd0;
        4:       limit = 7'd127;
        default: limit = 7'($urandom_range(0, 127));
      endcase
      if (phase > 0) begin
        write_limit(limit);
        src_pace = ($urandom_range(0, 2) != 0);
        snk_pace = ($urandom_range(0, 2) != 0);
      end
      target = bytes_sent + PhaseBytes;
      while (bytes_sent < target) begin
        kind  = $urandom_range(0, 9);
        shift = $urandom_range(1, 8);
        if (kind < 7 || (kind < 9 && shift == 1)) begin
          send_field(shift, 0, $urandom_range(0, 4) == 0);
        end else if (kind < 9) begin
          send_field(shift, $urandom_range(1, LEN_TABLE[shift-1] - 1), 1'b1);
        end else begin
          // noise: stray zero lead or any byte, buffer end at random
          send_byte($urandom_range(0, 1) ? 8'h00 : 8'($urandom_range(0, 255)),
                    $urandom_range(0, 3) == 0);
        end
      end
      // close the buffer so no field stays open across a limit change
      send_byte(8'($urandom_range(0, 255)), 1'b1);
    end

    wait_drained();
    $display("Run covered %0d input bytes and %0d limit writes over %0d phases.",
             bytes_sent, limit_writes, NumPhases);
    $display("Result words compared: %0d, mismatches: %0d.", checked, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/pvd_pkg.sv
hw/rtl/pvd_step.sv
hw/rtl/pvd_out_buf.sv
hw/rtl/prefix_varint_byte_decoder_top.sv
dv/prefix_varint_byte_decoder_checker.sv
dv/tb_prefix_varint_byte_decoder_top.sv
